// File: rtl/jnce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jnce_pkg
// Types and codes shared by the JTAG nibble command engine.
// ----------------------------------------------------------------------------
package jnce_pkg;

	typedef enum logic [1:0] {
		MODE_CMD      = 2'd0,
		MODE_READ_CLR = 2'd1,
		MODE_PEEK     = 2'd2,
		MODE_RESET    = 2'd3
	} mode_t;

	localparam logic [3:0] CODE_NOP   = 4'h0;
	localparam logic [3:0] CODE_SYNC  = 4'h1;
	localparam logic [3:0] MASK_CLASS = 4'hc;
	localparam logic [3:0] CLASS_TCK  = 4'h4;
	localparam logic [3:0] MASK_CHECK = 4'h8;

	localparam logic KIND_TCK    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic       packet_start;
		logic [7:0] command_byte;
		logic       tdo_low;
		logic       tdo_high;
	} in_word_t;

	typedef struct packed {
		logic kind;
		logic tms;
		logic tdi;
		logic tdo_checked;
		logic tdo_mismatch;
		logic error_flag;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} res_slot_t;

	typedef struct packed {
		res_slot_t slot;
		logic      skip;
		logic      err;
	} lane_out_t;

endpackage
`default_nettype wire

// File: rtl/jtag_nibble_command_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtag_nibble_command_engine
// Plays command bytes of two JTAG nibble codes as TCK cycle words.
//
// Channel cmd carries one input word (mode, packet_start, command_byte,
// tdo_low, tdo_high); channel res carries result words, one per TCK cycle
// or status report, with last set on the final word of an input word.
// Both channels: a word moves when valid is high and stall is low.
// Two decode lanes handle the low and high nibble in the cycle a word is
// accepted; the merge stage buffers up to two results. Unless res stalls,
// words leave and bytes with one or no result are taken at one per cycle;
// a byte that yields two TCK words fills both entries and the next waits until
// its first word has left. Results appear in the cycle after acceptance.
// The buffer sets the pace: cmd stalls while it holds more than the word
// leaving this cycle. A stall on res holds the shown word.
// Reset (arst_n low) clears skip state, the error flag and the buffer.
// ----------------------------------------------------------------------------
module jtag_nibble_command_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire jnce_pkg::in_word_t  cmd,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output jnce_pkg::out_word_t      res
);
	import jnce_pkg::*;

	logic      skip_q, err_q;
	logic      ready, accept, skip_start;
	lane_out_t lane_lo, lane_hi;
	res_slot_t slot_a, slot_b;
	mode_t     mode;

	assign mode = mode_t'(cmd.mode);
	assign cmd_stall = !ready;
	assign accept = cmd_valid && ready;
	assign skip_start = skip_q && !cmd.packet_start;

	jnce_lane u_lane_lo (
		.code    (cmd.command_byte[3:0]),
		.tdo     (cmd.tdo_low),
		.skip_in (skip_start),
		.err_in  (err_q),
		.lane    (lane_lo)
	);

	jnce_lane u_lane_hi (
		.code    (cmd.command_byte[7:4]),
		.tdo     (cmd.tdo_high),
		.skip_in (lane_lo.skip),
		.err_in  (lane_lo.err),
		.lane    (lane_hi)
	);

	always_comb begin
		slot_a = lane_lo.slot;
		slot_b = lane_hi.slot;
		if (mode == MODE_READ_CLR || mode == MODE_PEEK) begin
			slot_a = '0;
			slot_a.valid = 1'b1;
			slot_a.word.kind = KIND_STATUS;
			slot_a.word.error_flag = err_q;
			slot_b.valid = 1'b0;
		end else if (mode == MODE_RESET) begin
			slot_a.valid = 1'b0;
			slot_b.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			unique case (mode)
				MODE_CMD: begin
					skip_q <= lane_hi.skip;
					err_q <= lane_hi.err;
				end
				MODE_READ_CLR: begin
					err_q <= 1'b0;
				end
				MODE_PEEK: begin
					err_q <= err_q;
				end
				MODE_RESET: begin
					skip_q <= 1'b0;
					err_q <= 1'b0;
				end
				default: begin
					err_q <= err_q;
				end
			endcase
		end
	end

	jnce_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.lane_a    (slot_a),
		.lane_b    (slot_b),
		.ready     (ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
`default_nettype wire

// File: rtl/jnce_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jnce_lane
// Decodes one 4-bit JTAG code against the incoming skip and error state.
// ----------------------------------------------------------------------------
module jnce_lane (
	input  wire logic [3:0]         code,
	input  wire logic               tdo,
	input  wire logic               skip_in,
	input  wire logic               err_in,
	output jnce_pkg::lane_out_t     lane
);
	import jnce_pkg::*;

	logic mis;

	always_comb begin
		mis = (code[2] != tdo);
		lane = '0;
		lane.skip = 1'b0;
		lane.err = err_in;
		lane.slot.word.kind = KIND_TCK;
		lane.slot.word.tms = code[1];
		lane.slot.word.tdi = code[0];
		lane.slot.word.error_flag = err_in;
		priority if (skip_in) begin
			lane.slot.valid = 1'b0;
		end else if (code == CODE_NOP) begin
			lane.slot.valid = 1'b0;
		end else if (code == CODE_SYNC) begin
			lane.skip = 1'b1;
		end else if ((code & MASK_CLASS) == CLASS_TCK) begin
			lane.slot.valid = 1'b1;
		end else if ((code & MASK_CHECK) == MASK_CHECK) begin
			lane.slot.valid = 1'b1;
			lane.slot.word.tdo_checked = 1'b1;
			lane.slot.word.tdo_mismatch = mis;
			lane.err = err_in | mis;
			lane.slot.word.error_flag = err_in | mis;
		end else begin
			lane.slot.valid = 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/jnce_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jnce_merge
// Packs the lane results of one word into a two-entry output buffer and
// plays them out, one word per cycle unless stalled, marking the final one.
// ----------------------------------------------------------------------------
module jnce_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire jnce_pkg::res_slot_t lane_a,
	input  wire jnce_pkg::res_slot_t lane_b,
	output logic                     ready,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output jnce_pkg::out_word_t      res
);
	import jnce_pkg::*;

	out_word_t  slot0_q, slot1_q;
	out_word_t  slot0_d, slot1_d;
	logic [1:0] rem_q;
	logic       rd_q;
	logic [1:0] n;
	logic       pop;

	assign n = {1'b0, lane_a.valid} + {1'b0, lane_b.valid};
	assign res_valid = (rem_q != 2'd0);
	assign pop = res_valid && !res_stall;
	assign ready = (rem_q == 2'd0) || ((rem_q == 2'd1) && !res_stall);
	assign res = rd_q ? slot1_q : slot0_q;

	always_comb begin
		slot0_d = lane_a.valid ? lane_a.word : lane_b.word;
		slot0_d.last = !(lane_a.valid && lane_b.valid);
		slot1_d = lane_b.word;
		slot1_d.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			rd_q <= 1'b0;
		end else if (push) begin
			rem_q <= n;
			rd_q <= 1'b0;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
			rd_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= slot0_d;
			slot1_q <= slot1_d;
		end
	end

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 2'd3) else $error("buffer count out of range");
	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready) else $error("push while buffer busy");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && n != 2'd0) |=> res_valid) else $error("pushed results not shown");
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == 2'd1) |-> res.last) else $error("final word lacks last");
`endif

endmodule
`default_nettype wire
